// ===== hdl/k_smallest_selector_macros.svh =====
// Assertion macros used by the RTL file k_smallest_selector.sv.
`ifndef K_SMALLEST_SELECTOR_MACROS_SVH
`define K_SMALLEST_SELECTOR_MACROS_SVH

`define KSEL_ASSERT_NOW(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

`define KSEL_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`define KSEL_ASSERT_THEN(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hdl/ksel_pkg.sv =====
package ksel_pkg;

  localparam int SCORE_BITS = 32;
  localparam int TAG_BITS   = 16;
  localparam int CAP_BITS   = 5;
  localparam int DATA_BITS  = 32;
  localparam int ADDR_BITS  = 3;

  localparam logic [CAP_BITS-1:0] CAP_RESET = 5'd16;

  localparam logic MODE_PUSH = 1'b0;
  localparam logic MODE_READ = 1'b1;

  localparam logic REG_CAPACITY = 1'b0;

  typedef struct packed {
    logic                  mode;
    logic [SCORE_BITS-1:0] score;
    logic [TAG_BITS-1:0]   tag;
  } req_t;

  typedef struct packed {
    logic [SCORE_BITS-1:0] threshold;
    logic                  full_res;
    logic [SCORE_BITS-1:0] item_score;
    logic [TAG_BITS-1:0]   item_tag;
    logic                  item_valid;
    logic                  last;
  } rsp_t;

  typedef struct packed {
    logic [SCORE_BITS-1:0] score;
    logic [TAG_BITS-1:0]   tag;
  } entry_t;

  typedef struct packed {
    logic insert;
    logic rotate;
    logic occupied;
    logic slot;
    logic shift_in;
    logic wrap;
  } cell_ctl_t;

endpackage

// ===== hdl/ksel_cell.sv =====
module ksel_cell
  import ksel_pkg::*;
(
  input  logic      clk,
  input  cell_ctl_t ctl,
  input  entry_t    new_entry,
  input  entry_t    left_entry,
  input  logic      left_gt,
  input  entry_t    right_entry,
  input  entry_t    head_entry,
  output entry_t    entry,
  output logic      gt
);

  assign gt = ctl.occupied && (entry.score > new_entry.score);

  always_ff @(posedge clk) begin
    if (ctl.insert && (gt || ctl.slot)) begin
      entry <= left_gt ? left_entry : new_entry;
    end else if (ctl.rotate && ctl.shift_in) begin
      entry <= right_entry;
    end else if (ctl.rotate && ctl.wrap) begin
      entry <= head_entry;
    end
  end

endmodule

// ===== hdl/k_smallest_selector.sv =====
// Keeps the smallest-scored entries of a stream in a chain of cells sorted by ascending
// score, equal scores in arrival order. On a push the chain compares every cell
// with the new score and shifts as it is accepted; S_PUSH then registers the result
// (threshold and full flag after the push) once the output register is free. Readout
// entries leave one at a time through the head cell (an empty readout sends one)
// while the chain rotates once around, so the store ends intact; the single head read
// port sets this pace. Results wait in an output register; a stalled consumer holds it
// and the push or readout. Capacity writes drop the largest excess entries at once.
module k_smallest_selector
  import ksel_pkg::*;
#(
  parameter int CAPACITY = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  req_t                 req,
  input  logic                 req_valid,
  output logic                 req_stall,
  output rsp_t                 rsp,
  output logic                 rsp_valid,
  input  logic                 rsp_stall,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [ADDR_BITS-1:0] paddr,
  input  logic [DATA_BITS-1:0] pwdata,
  output logic [DATA_BITS-1:0] prdata,
  output logic                 pready
);

`include "k_smallest_selector_macros.svh"

  localparam int CW = $clog2(CAPACITY + 1);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_PUSH = 3'b010,
    S_READ = 3'b100
  } state_t;

  state_t                state;
  logic [CW-1:0]         count;
  logic [CAP_BITS-1:0]   cap;
  logic [CW-1:0]         rd_idx;
  logic [SCORE_BITS-1:0] thr_hold;
  logic                  full_hold;

  entry_t                cell_entry [CAPACITY];
  logic [CAPACITY-1:0]   cell_gt;
  cell_ctl_t             cell_ctl [CAPACITY];

  logic [CW-1:0]         eff_cap;
  logic [CW-1:0]         new_eff;
  logic [CW-1:0]         count_m1;
  logic [CW-1:0]         ins_cnt;
  logic [SCORE_BITS-1:0] tail_score;
  logic [SCORE_BITS-1:0] thr_now;
  logic                  full_now;
  logic                  push_hit;
  logic                  accept;
  logic                  do_insert;
  logic                  rotate;
  logic                  out_free;
  logic                  cfg_wr;
  entry_t                new_entry;

  function automatic logic [CW-1:0] eff_of(input logic [CAP_BITS-1:0] c);
    logic [CW-1:0] r;
    if (c == '0) begin
      r = CW'(1);
    end else if (32'(c) > CAPACITY) begin
      r = CW'(CAPACITY);
    end else begin
      r = CW'(c);
    end
    return r;
  endfunction

  assign pready = 1'b1;
  assign prdata = DATA_BITS'(cap);
  assign cfg_wr = psel && penable && pwrite;

  assign eff_cap  = eff_of(cap);
  assign new_eff  = eff_of(pwdata[CAP_BITS-1:0]);
  assign count_m1 = count - CW'(1);
  assign full_now = count >= eff_cap;
  assign thr_now  = full_now ? tail_score : '1;

  always_comb begin
    tail_score = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (CW'(i) == count_m1) begin
        tail_score = tail_score | cell_entry[i].score;
      end
    end
  end

  assign req_stall = (state != S_IDLE);
  assign accept    = req_valid && !req_stall;
  assign push_hit  = !full_now || (req.score < tail_score);
  assign ins_cnt   = full_now ? count_m1 : count;
  assign do_insert = accept && (req.mode == MODE_PUSH) && push_hit;
  assign out_free  = !rsp_valid || !rsp_stall;
  assign rotate    = (state == S_READ) && out_free && (count != '0);
  assign new_entry = '{score: req.score, tag: req.tag};

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    assign cell_ctl[i] = '{
      insert:   do_insert,
      rotate:   rotate,
      occupied: CW'(i) < ins_cnt,
      slot:     CW'(i) == ins_cnt,
      shift_in: CW'(i + 1) < count,
      wrap:     CW'(i + 1) == count
    };

    ksel_cell u_cell (
      .clk         (clk),
      .ctl         (cell_ctl[i]),
      .new_entry   (new_entry),
      .left_entry  ((i == 0) ? new_entry : cell_entry[(i == 0) ? 0 : i - 1]),
      .left_gt     ((i == 0) ? 1'b0 : cell_gt[(i == 0) ? 0 : i - 1]),
      .right_entry ((i == CAPACITY - 1) ? cell_entry[0]
                                        : cell_entry[(i == CAPACITY - 1) ? 0 : i + 1]),
      .head_entry  (cell_entry[0]),
      .entry       (cell_entry[i]),
      .gt          (cell_gt[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      cap       <= CAP_RESET;
      rsp_valid <= 1'b0;
    end else begin
      if (rsp_valid && !rsp_stall) begin
        rsp_valid <= 1'b0;
      end
      if (cfg_wr && (paddr[2] == REG_CAPACITY)) begin
        cap <= pwdata[CAP_BITS-1:0];
        if (count > new_eff) begin
          count <= new_eff;
        end
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            if (req.mode == MODE_PUSH) begin
              if (push_hit) begin
                count <= ins_cnt + CW'(1);
              end
              state <= S_PUSH;
            end else begin
              rd_idx    <= '0;
              thr_hold  <= thr_now;
              full_hold <= full_now;
              state     <= S_READ;
            end
          end
        end
        S_PUSH: begin
          if (out_free) begin
            rsp_valid <= 1'b1;
            rsp       <= '{threshold: thr_now, full_res: full_now, item_score: '0,
                           item_tag: '0, item_valid: 1'b0, last: 1'b1};
            state     <= S_IDLE;
          end
        end
        S_READ: begin
          if (out_free) begin
            rsp_valid <= 1'b1;
            if (count == '0) begin
              rsp   <= '{threshold: thr_hold, full_res: full_hold, item_score: '0,
                         item_tag: '0, item_valid: 1'b0, last: 1'b1};
              state <= S_IDLE;
            end else begin
              rsp    <= '{threshold: thr_hold, full_res: full_hold,
                          item_score: cell_entry[0].score, item_tag: cell_entry[0].tag,
                          item_valid: 1'b1, last: rd_idx == count_m1};
              rd_idx <= rd_idx + CW'(1);
              if (rd_idx == count_m1) begin
                state <= S_IDLE;
              end
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `KSEL_ASSERT_NOW(a_count_fits, count <= eff_cap, "kept count exceeds capacity")
  `KSEL_ASSERT_THEN(a_push_result, accept && req.mode == MODE_PUSH, state == S_PUSH, "push did not go to result")
  `KSEL_ASSERT_SAME(a_mid_readout, rsp_valid && !rsp.last, state == S_READ, "non-final item outside readout")
  `KSEL_ASSERT_SAME(a_idx_range, state == S_READ && count != '0, rd_idx < count, "readout index past count")

endmodule
